/* rtl/tile_cache_farthest_replace_unit_defines.svh */
// Assertion macros for the tile cache replace unit
`ifndef TILE_CACHE_FARTHEST_REPLACE_UNIT_DEFINES_SVH
`define TILE_CACHE_FARTHEST_REPLACE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define TCFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tcfr_pkg.sv */
// Types and constants shared by the tile cache replace unit
`default_nettype none

package tcfr_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned SLOT_FIELD_W = 5;

    localparam logic signed [COORD_W-1:0] RESET_TAG = 16'sd9999;

    localparam logic [1:0] OP_GET       = 2'd0;
    localparam logic [1:0] OP_FLUSH_ONE = 2'd1;
    localparam logic [1:0] OP_FLUSH_ALL = 2'd2;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] cell_x;
        logic signed [COORD_W-1:0] cell_y;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    hit;
        logic                    redraw;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] col;
        logic signed [COORD_W-1:0] row;
        logic                      stale;
    } t_slot_ent;

    typedef struct packed {
        logic found;
        logic hit_stale;
    } t_scan_flags;

endpackage

`default_nettype wire

/* rtl/tile_cache_farthest_replace_unit.sv */
// Top level of the fully associative tile cache with farthest-tag eviction
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+----------------------------------
//  input   | i_in_valid   | o_in_stall   | i_in  (operation, cell_x, cell_y)
//  output  | o_out_valid  | i_out_stall  | o_out (slot, hit, redraw)
//
// Each transaction passes through scan, drain, apply and done before the next
// acceptance: the slot ring is rotated once past the head scanner, the drain state
// empties the distance pipeline, then a second rotation writes the update back.
// A result held in the output register while the output is stalled lets the
// next transaction run; it waits in its last state until the register frees.
// Synchronous reset loads every slot with the reset tag, not stale.
`default_nettype none
`include "tile_cache_farthest_replace_unit_defines.svh"

module tile_cache_farthest_replace_unit
    import tcfr_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out,
    input  wire logic      i_out_stall
);

    localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SW-1:0] LAST = SW'(NUM_SLOTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state   r_state, n_state;
    logic [SW-1:0] r_cnt, n_cnt;
    t_in_item r_req;
    logic     r_o_valid, n_o_valid;
    t_out_item r_out, n_out;

    t_slot_ent   w_ent [NUM_SLOTS];
    t_slot_ent   w_wb;
    logic        w_shift;
    logic        w_start;
    logic        w_step;
    t_scan_flags w_flags;
    logic [SW-1:0] w_hit_idx;
    logic [SW-1:0] w_victim;
    logic        w_sel_hit;
    logic        w_sel_vic;
    logic        w_out_free;
    logic [SW+SLOT_FIELD_W-1:0] w_slot_ext;

    // ring: cell g loads from cell g+1, the last cell from the head write-back
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        t_slot_ent w_nxt;
        if (g == NUM_SLOTS - 1) begin : g_tail
            assign w_nxt = w_wb;
        end else begin : g_mid
            assign w_nxt = w_ent[g+1];
        end
        tcfr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_ent   (w_nxt),
            .o_ent   (w_ent[g])
        );
    end

    tcfr_scan #(
        .SLOT_W (SW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_step    (w_step),
        .i_idx     (r_cnt),
        .i_ent     (w_ent[0]),
        .i_x       (r_req.cell_x),
        .i_y       (r_req.cell_y),
        .o_flags   (w_flags),
        .o_hit_idx (w_hit_idx),
        .o_victim  (w_victim)
    );

    assign w_start    = (r_state == ST_IDLE) && i_in_valid;
    assign w_step     = (r_state == ST_SCAN);
    assign w_shift    = (r_state == ST_SCAN) || (r_state == ST_APPLY);
    assign w_sel_hit  = w_flags.found && (r_cnt == w_hit_idx);
    assign w_sel_vic  = !w_flags.found && (r_cnt == w_victim);
    assign w_out_free = !r_o_valid || !i_out_stall;

    // head entry as written back into the ring during the update pass
    always_comb begin
        w_wb = w_ent[0];
        if (r_state == ST_APPLY) begin
            unique case (r_req.operation)
                OP_GET: begin
                    if (w_sel_hit) begin
                        w_wb.stale = 1'b0;
                    end else if (w_sel_vic) begin
                        w_wb.col   = r_req.cell_x;
                        w_wb.row   = r_req.cell_y;
                        w_wb.stale = 1'b0;
                    end
                end
                OP_FLUSH_ONE: begin
                    if (w_sel_hit) begin
                        w_wb.stale = 1'b1;
                    end
                end
                OP_FLUSH_ALL: begin
                    w_wb.stale = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // result for the finished transaction
    always_comb begin
        n_out      = '0;
        w_slot_ext = '0;
        unique case (r_req.operation)
            OP_GET: begin
                w_slot_ext   = {{SLOT_FIELD_W{1'b0}},
                                (w_flags.found ? w_hit_idx : w_victim)};
                n_out.slot   = w_slot_ext[SLOT_FIELD_W-1:0];
                n_out.hit    = w_flags.found;
                n_out.redraw = w_flags.found ? w_flags.hit_stale : 1'b1;
            end
            OP_FLUSH_ONE: begin
                n_out.hit = w_flags.found;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_o_valid = r_o_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_req <= i_in;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out       = r_out;

    `TCFR_ASSERT_NXT(a_scan_to_drain, (r_state == ST_SCAN) && (r_cnt == LAST), (r_state == ST_DRAIN) && (r_cnt == '0), "scan pass did not end in drain")
    `TCFR_ASSERT_NXT(a_drain_to_apply, (r_state == ST_DRAIN), (r_state == ST_APPLY) && (r_cnt == '0), "update pass did not start at slot zero")
    `TCFR_ASSERT_NXT(a_done_waits, (r_state == ST_DONE) && r_o_valid && i_out_stall, (r_state == ST_DONE) && r_o_valid, "held result overwritten by next transaction")
    `TCFR_ASSERT_IMP(a_miss_redraw, (r_state == ST_DONE) && (r_req.operation == OP_GET) && !w_flags.found, n_out.redraw && !n_out.hit, "get miss without redraw")

endmodule

`default_nettype wire

/* rtl/tcfr_cell.sv */
// One slot of the tag ring: holds a tag pair and stale mark, loads from its neighbour
`default_nettype none

module tcfr_cell
    import tcfr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_shift,
    input  wire t_slot_ent i_ent,
    output t_slot_ent      o_ent
);

    t_slot_ent r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.col   <= RESET_TAG;
            r_ent.row   <= RESET_TAG;
            r_ent.stale <= 1'b0;
        end else if (i_shift) begin
            r_ent <= i_ent;
        end
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

/* rtl/tcfr_scan.sv */
// Head-of-ring scanner: first tag match and farthest slot by squared distance
`default_nettype none

module tcfr_scan
    import tcfr_pkg::*;
#(
    parameter int unsigned SLOT_W = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_step,
    input  wire logic [SLOT_W-1:0]         i_idx,
    input  wire t_slot_ent                 i_ent,
    input  wire logic signed [COORD_W-1:0] i_x,
    input  wire logic signed [COORD_W-1:0] i_y,
    output t_scan_flags                    o_flags,
    output logic [SLOT_W-1:0]              o_hit_idx,
    output logic [SLOT_W-1:0]              o_victim
);

    localparam int unsigned SQ_W = 2 * COORD_W;
    localparam int unsigned DIST_W = SQ_W + 1;

    logic signed [COORD_W:0] w_dc;
    logic signed [COORD_W:0] w_dr;
    logic [COORD_W-1:0]      w_mc;
    logic [COORD_W-1:0]      w_mr;
    logic                    w_match;
    logic [DIST_W-1:0]       w_dist;

    logic                r_found;
    logic                r_hit_stale;
    logic [SLOT_W-1:0]   r_hit_idx;
    logic                r_a_vld;
    logic [SLOT_W-1:0]   r_a_idx;
    logic [SQ_W-1:0]     r_sq_c;
    logic [SQ_W-1:0]     r_sq_r;
    logic [DIST_W-1:0]   r_best;
    logic [SLOT_W-1:0]   r_victim;

    // magnitude of a 16-bit signed difference always fits in 16 bits
    always_comb begin
        w_dc = {i_ent.col[COORD_W-1], i_ent.col} - {i_x[COORD_W-1], i_x};
        w_dr = {i_ent.row[COORD_W-1], i_ent.row} - {i_y[COORD_W-1], i_y};
        w_mc = w_dc[COORD_W] ? COORD_W'(-w_dc) : w_dc[COORD_W-1:0];
        w_mr = w_dr[COORD_W] ? COORD_W'(-w_dr) : w_dr[COORD_W-1:0];
        w_match = (i_ent.col == i_x) && (i_ent.row == i_y);
        w_dist = {1'b0, r_sq_c} + {1'b0, r_sq_r};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_hit_stale <= 1'b0;
            r_hit_idx   <= '0;
            r_a_vld     <= 1'b0;
            r_best      <= '0;
            r_victim    <= '0;
        end else if (i_start) begin
            r_found     <= 1'b0;
            r_hit_stale <= 1'b0;
            r_hit_idx   <= '0;
            r_a_vld     <= 1'b0;
            r_best      <= '0;
            r_victim    <= '0;
        end else begin
            r_a_vld <= i_step;
            if (i_step && !r_found && w_match) begin
                r_found     <= 1'b1;
                r_hit_stale <= i_ent.stale;
                r_hit_idx   <= i_idx;
            end
            // strict compare keeps the lowest slot on ties
            if (r_a_vld && (w_dist > r_best)) begin
                r_best   <= w_dist;
                r_victim <= r_a_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_sq_c  <= SQ_W'(w_mc) * SQ_W'(w_mc);
            r_sq_r  <= SQ_W'(w_mr) * SQ_W'(w_mr);
            r_a_idx <= i_idx;
        end
    end

    assign o_flags.found     = r_found;
    assign o_flags.hit_stale = r_hit_stale;
    assign o_hit_idx         = r_hit_idx;
    assign o_victim          = r_victim;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the tile cache with farthest-tag eviction
`timescale 1ns / 1ps

module tb_top;
    import tcfr_pkg::*;

    localparam int unsigned N_SLOTS      = 32;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          IDLE_LIMIT   = 5000;
    localparam int          DRAIN_CYCLES = 2 * N_SLOTS + 3 + 16;
    localparam int          POOL_SIZE    = 48;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;
    logic      i_out_stall = 1'b0;

    tile_cache_farthest_replace_unit #(
        .NUM_SLOTS(N_SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the slot tags and stale marks
    logic signed [15:0] held_col [N_SLOTS];
    logic signed [15:0] held_row [N_SLOTS];
    logic               held_stale [N_SLOTS];

    t_out_item tile_answers_q [$];
    t_out_item due;

    int n_errors = 0;
    int n_results = 0;
    int n_gets = 0, n_get_hits = 0, n_get_misses = 0;
    int n_flush_one = 0, n_flush_one_hits = 0, n_flush_all = 0, n_unused = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    logic [8:0] stall_phase = '0;
    int stall_mode = 0;

    logic signed [15:0] pool_x [POOL_SIZE];
    logic signed [15:0] pool_y [POOL_SIZE];

    function automatic void clear_tiles();
        for (int i = 0; i < N_SLOTS; i++) begin
            held_col[i]   = RESET_TAG;
            held_row[i]   = RESET_TAG;
            held_stale[i] = 1'b0;
        end
    endfunction

    function automatic int find_tile(logic signed [15:0] x, logic signed [15:0] y);
        for (int i = 0; i < N_SLOTS; i++)
            if (held_col[i] == x && held_row[i] == y)
                return i;
        return -1;
    endfunction

    // applies one request to the shadow cache and returns the answer it yields
    function automatic t_out_item serve_tile_req(t_in_item req);
        t_out_item          ans;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        longint             dx, dy, sq_dist, best;
        int                 s;
        ans = '0;
        cx = req.cell_x;
        cy = req.cell_y;
        case (req.operation)
            OP_GET: begin
                s = find_tile(cx, cy);
                if (s >= 0) begin
                    ans.hit    = 1'b1;
                    ans.redraw = held_stale[s];
                end else begin
                    best = 0;
                    s = 0;
                    for (int i = 0; i < N_SLOTS; i++) begin
                        dx = longint'(held_col[i]) - longint'(cx);
                        dy = longint'(held_row[i]) - longint'(cy);
                        sq_dist = dx * dx + dy * dy;
                        if (sq_dist > best) begin
                            best = sq_dist;
                            s = i;
                        end
                    end
                    held_col[s] = cx;
                    held_row[s] = cy;
                    ans.redraw  = 1'b1;
                end
                held_stale[s] = 1'b0;
                ans.slot = s[4:0];
            end
            OP_FLUSH_ONE: begin
                s = find_tile(cx, cy);
                if (s >= 0) begin
                    held_stale[s] = 1'b1;
                    ans.hit = 1'b1;
                end
            end
            OP_FLUSH_ALL: begin
                for (int i = 0; i < N_SLOTS; i++)
                    held_stale[i] = 1'b1;
            end
            default: ;
        endcase
        return ans;
    endfunction

    // drives one transaction, with random bursts and gaps on the sending side
    task automatic send_tile_req(input logic [1:0] op, input logic signed [15:0] x,
                                 input logic signed [15:0] y);
        t_in_item  req;
        t_out_item ans;
        req.operation = op;
        req.cell_x    = x;
        req.cell_y    = y;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_stall);
        ans = serve_tile_req(req);
        tile_answers_q.push_back(ans);
        case (op)
            OP_GET: begin
                n_gets++;
                if (ans.hit) n_get_hits++;
                else n_get_misses++;
            end
            OP_FLUSH_ONE: begin
                n_flush_one++;
                if (ans.hit) n_flush_one_hits++;
            end
            OP_FLUSH_ALL: n_flush_all++;
            default: n_unused++;
        endcase
    endtask

    // receiver: picks a new stall habit each time the low byte of stall_phase is all ones
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 0);
            2: i_out_stall <= ($urandom_range(0, 9) != 0);
            default: i_out_stall <= stall_phase[3];
        endcase
        if (stall_phase[7:0] == 8'hff)
            stall_mode <= $urandom_range(0, 3);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (tile_answers_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result slot=%0d hit=%0b redraw=%0b",
                         $time, o_out.slot, o_out.hit, o_out.redraw);
            end else begin
                due = tile_answers_q.pop_front();
                if (o_out.slot !== due.slot) begin
                    n_errors++;
                    $display("%0t: slot mismatch, expected %0d, got %0d",
                             $time, due.slot, o_out.slot);
                end
                if (o_out.hit !== due.hit) begin
                    n_errors++;
                    $display("%0t: hit mismatch, expected %0b, got %0b",
                             $time, due.hit, o_out.hit);
                end
                if (o_out.redraw !== due.redraw) begin
                    n_errors++;
                    $display("%0t: redraw mismatch, expected %0b, got %0b",
                             $time, due.redraw, o_out.redraw);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("tile_cache_farthest_replace_unit test failed");
            $finish;
        end
    end

    // reset tag: slots still hold 9999 and are not stale
    task automatic test_reset_tag();
        send_tile_req(OP_GET, RESET_TAG, RESET_TAG);
        send_tile_req(OP_FLUSH_ONE, RESET_TAG, RESET_TAG);
        send_tile_req(OP_GET, RESET_TAG, RESET_TAG);
        send_tile_req(OP_GET, RESET_TAG, RESET_TAG);
    endtask

    // corner coordinates, equal-distance ties and far evictions
    task automatic test_extremes();
        send_tile_req(OP_GET, 16'sd0, 16'sd0);
        send_tile_req(OP_GET, -16'sd32768, -16'sd32768);
        send_tile_req(OP_GET, 16'sd32767, 16'sd32767);
        send_tile_req(OP_GET, 16'sd32767, -16'sd32768);
        send_tile_req(OP_GET, -16'sd32768, 16'sd32767);
        send_tile_req(OP_GET, -16'sd1, -16'sd1);
        send_tile_req(OP_GET, 16'sd0, 16'sd0);
        send_tile_req(OP_GET, -16'sd32768, -16'sd32768);
    endtask

    // flush-one hit and miss, flush-all, then the unused code
    task automatic test_flushes();
        send_tile_req(OP_FLUSH_ONE, 16'sd0, 16'sd0);
        send_tile_req(OP_FLUSH_ONE, 16'sd1234, -16'sd4321);
        send_tile_req(OP_GET, 16'sd0, 16'sd0);
        send_tile_req(OP_FLUSH_ALL, 16'sd0, 16'sd0);
        send_tile_req(OP_GET, 16'sd32767, 16'sd32767);
        send_tile_req(OP_GET, 16'sd32767, 16'sd32767);
        send_tile_req(OP_FLUSH_ONE, -16'sd1, -16'sd1);
        send_tile_req(OP_GET, -16'sd1, -16'sd1);
        send_tile_req(OP_UNUSED, -16'sd1, -16'sd1);
        send_tile_req(OP_GET, -16'sd1, -16'sd1);
    endtask

    function automatic logic signed [15:0] near_coord(logic signed [15:0] centre);
        return centre + 16'($urandom_range(0, 15)) - 16'sd8;
    endfunction

    function automatic void refill_pool(int i);
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        cx = pool_x[(i + 1) % POOL_SIZE];
        cy = pool_y[(i + 1) % POOL_SIZE];
        case ($urandom_range(0, 9))
            0: begin
                pool_x[i] = 16'($urandom_range(0, 65535));
                pool_y[i] = 16'($urandom_range(0, 65535));
            end
            1: begin
                pool_x[i] = RESET_TAG;
                pool_y[i] = RESET_TAG;
            end
            default: begin
                pool_x[i] = near_coord(cx);
                pool_y[i] = near_coord(cy);
            end
        endcase
    endfunction

    // mostly re-used tiles from a working set a bit larger than the cache
    task automatic test_random_traffic(input int n_items);
        int done;
        int r;
        int p;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        done = 0;
        cx = 16'($urandom_range(0, 65535));
        cy = 16'($urandom_range(0, 65535));
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_x[i] = near_coord(cx);
            pool_y[i] = near_coord(cy);
        end
        while (done < n_items) begin
            r = $urandom_range(0, 99);
            p = $urandom_range(0, POOL_SIZE - 1);
            if (r < 55) begin
                send_tile_req(OP_GET, pool_x[p], pool_y[p]);
            end else if (r < 65) begin
                refill_pool(p);
                send_tile_req(OP_GET, pool_x[p], pool_y[p]);
            end else if (r < 80) begin
                send_tile_req(OP_FLUSH_ONE, pool_x[p], pool_y[p]);
            end else if (r < 86) begin
                send_tile_req(OP_FLUSH_ONE, 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
            end else if (r < 91) begin
                send_tile_req(OP_FLUSH_ALL, 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
            end else if (r < 93) begin
                // ignored by the block, not counted
                send_tile_req(OP_UNUSED, 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
                done--;
            end else begin
                send_tile_req(OP_GET, 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
            end
            done++;
        end
    endtask

    initial begin
        clear_tiles();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_tag();
        test_extremes();
        test_flushes();
        test_random_traffic(830);

        i_in_valid <= 1'b0;
        while (tile_answers_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d gets (%0d hits, %0d misses), %0d flush-one (%0d hits),",
                 n_gets, n_get_hits, n_get_misses, n_flush_one, n_flush_one_hits);
        $display("%0d flush-all, %0d unused codes; %0d results checked, %0d mismatches",
                 n_flush_all, n_unused, n_results, n_errors);
        if (n_errors == 0)
            $display("tile_cache_farthest_replace_unit test passed");
        else
            $display("tile_cache_farthest_replace_unit test failed");
        $finish;
    end

endmodule
